// ===== rtl/hdr_color_pack_unpack_unit_assert.svh =====
// Assertion macros for the HDR color pack/unpack unit.
// Expects clk and arst_n in the including scope.
`ifndef HDR_COLOR_PACK_UNPACK_UNIT_ASSERT_SVH
`define HDR_COLOR_PACK_UNPACK_UNIT_ASSERT_SVH

// same-cycle implication
`define HCP_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hcp check failed");

// next-cycle implication
`define HCP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hcp check failed");

`endif

// ===== rtl/hcp_pkg.sv =====
// Shared types, constants and step functions of the HDR color pack/unpack unit.
// No dependencies.
package hcp_pkg;

	localparam logic [14:0] DIV_D    = 15'd32385;
	localparam logic [13:0] HDR_SQ   = 14'd16129;
	localparam logic [6:0]  HDR_MAX  = 7'd127;
	localparam int          QF_BITS  = 16;
	localparam int          CELL_NUM = 8;
	localparam int          HDR_LANE = 3;

	typedef struct packed {
		logic [7:0]  acc;
		logic [15:0] acc_sq;
		logic [39:0] m;
		logic [47:0] t;
	} sq_lane_t;

	typedef struct packed {
		logic [3:0]  q1;
		logic [14:0] rem;
		logic [15:0] qf;
	} div_lane_t;

	typedef struct packed {
		logic              func;
		logic              alpha;
		logic              zero;
		sq_lane_t [3:0]    sq;
		div_lane_t [2:0]   dv;
	} cell_data_t;

	function automatic sq_lane_t sq_step(sq_lane_t l, logic [2:0] pos);
		sq_lane_t    r;
		logic [7:0]  k;
		logic [15:0] ksq;
		logic [55:0] prod;
		r    = l;
		k    = l.acc | (8'd1 << pos);
		ksq  = l.acc_sq + (16'(l.acc) << (4'(pos) + 4'd1)) + (16'd1 << {pos, 1'b0});
		prod = 56'(ksq) * 56'(l.m);
		if (prod <= 56'(l.t)) begin
			r.acc    = k;
			r.acc_sq = ksq;
		end
		return r;
	endfunction

	function automatic div_lane_t div_step(div_lane_t d);
		div_lane_t   r;
		logic [15:0] r2;
		r  = d;
		r2 = {d.rem, 1'b0};
		if (r2 >= 16'(DIV_D)) begin
			r.rem = 15'(r2 - 16'(DIV_D));
			r.qf  = {d.qf[14:0], 1'b1};
		end else begin
			r.rem = r2[14:0];
			r.qf  = {d.qf[14:0], 1'b0};
		end
		return r;
	endfunction

endpackage

// ===== rtl/hdr_color_pack_unpack_unit.sv =====
// Top level of the HDR color pack/unpack unit: front stages, cell chain, output register.
// Depends on hcp_pkg, hcp_front, hcp_cell and hdr_color_pack_unpack_unit_assert.svh.
//
// Usage: each input transaction (in_valid high, in_stall low) carries one operation.
// func 0 encodes red_in/green_in/blue_in/alpha_in into packed_out; func 1 decodes
// packed_in into red_out/green_out/blue_out/alpha_out. Fields not used by the
// operation are driven to zero on the output.
// Each transaction passes twelve registers, the first loaded at the accepting edge:
// three front stages, eight chain cells (one root bit and two quotient bits each)
// and the output register. Throughput: one transaction per cycle unless out_stall holds
// a result; every stage holds one item and hands it on.
// Reset clears every valid bit; the unit takes transactions in the first cycle after.
// When out_stall holds a result, stages behind it keep filling until the chain is
// full; in_stall rises only when every stage holds an item.
`include "hdr_color_pack_unpack_unit_assert.svh"

module hdr_color_pack_unpack_unit #(
	parameter int FRACTION_BITS = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        func,
	input  logic [15:0] red_in,
	input  logic [15:0] green_in,
	input  logic [15:0] blue_in,
	input  logic [15:0] alpha_in,
	input  logic [31:0] packed_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] packed_out,
	output logic [15:0] red_out,
	output logic [15:0] green_out,
	output logic [15:0] blue_out,
	output logic        alpha_out
);

	localparam int N = hcp_pkg::CELL_NUM;

	hcp_pkg::cell_data_t chain_d [0:N];
	logic                chain_v [0:N];
	logic                chain_s [0:N];

	logic                out_valid_q, last_stall, func_q;
	logic [31:0]         packed_q, packed_c;
	logic [2:0][15:0]    chan_q, chan_c;
	logic                alpha_q;
	logic [6:0]          hdr_c;
	logic [23:0]         val_c;

	hcp_front #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.func     (func),
		.red_in   (red_in),
		.green_in (green_in),
		.blue_in  (blue_in),
		.alpha_in (alpha_in),
		.packed_in(packed_in),
		.out_valid(chain_v[0]),
		.out_stall(chain_s[0]),
		.out_data (chain_d[0])
	);

	for (genvar i = 0; i < N; i++) begin : g_cell
		hcp_cell #(
			.BIT(N - 1 - i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (chain_v[i]),
			.in_stall (chain_s[i]),
			.in_data  (chain_d[i]),
			.out_valid(chain_v[i + 1]),
			.out_stall(chain_s[i + 1]),
			.out_data (chain_d[i + 1])
		);
	end

	assign last_stall = out_valid_q && out_stall;
	assign chain_s[N] = last_stall;

	always_comb begin
		hdr_c = (chain_d[N].sq[hcp_pkg::HDR_LANE].acc > 8'(hcp_pkg::HDR_MAX))
			? hcp_pkg::HDR_MAX : chain_d[N].sq[hcp_pkg::HDR_LANE].acc[6:0];
		packed_c = '0;
		chan_c   = '0;
		val_c    = '0;
		if (!chain_d[N].func) begin
			if (chain_d[N].zero) begin
				packed_c = {chain_d[N].alpha, 31'd0};
			end else begin
				packed_c = {chain_d[N].alpha, hdr_c, chain_d[N].sq[2].acc,
					chain_d[N].sq[1].acc, chain_d[N].sq[0].acc};
			end
		end else begin
			for (int i = 0; i < 3; i++) begin
				val_c = (24'(chain_d[N].dv[i].q1) << FRACTION_BITS)
					| 24'(chain_d[N].dv[i].qf >> (hcp_pkg::QF_BITS - FRACTION_BITS));
				chan_c[i] = (val_c > 24'h00FFFF) ? 16'hFFFF : val_c[15:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!last_stall) begin
			out_valid_q <= chain_v[N];
		end
	end

	always_ff @(posedge clk) begin
		if (!last_stall) begin
			func_q   <= chain_d[N].func;
			packed_q <= packed_c;
			chan_q   <= chan_c;
			alpha_q  <= chain_d[N].func && chain_d[N].alpha;
		end
	end

	assign out_valid  = out_valid_q;
	assign packed_out = packed_q;
	assign red_out    = chan_q[2];
	assign green_out  = chan_q[1];
	assign blue_out   = chan_q[0];
	assign alpha_out  = alpha_q;

	`HCP_ASSERT_NOW(a_stall_origin, in_stall, out_valid && out_stall)
	`HCP_ASSERT_NOW(a_dec_word_zero, out_valid && func_q, packed_out == 32'd0)
	`HCP_ASSERT_NOW(a_enc_chan_zero, out_valid && !func_q,
		red_out == 16'd0 && green_out == 16'd0 && blue_out == 16'd0 && !alpha_out)
	`HCP_ASSERT_NEXT(a_hold_on_stall, out_valid && out_stall, out_valid)

endmodule

// ===== rtl/hcp_front.sv =====
// Front stages: squares, length sum, HDR target and coarse decode quotient.
// Depends on hcp_pkg.
module hcp_front #(
	parameter int FRACTION_BITS = 12
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               func,
	input  logic [15:0]        red_in,
	input  logic [15:0]        green_in,
	input  logic [15:0]        blue_in,
	input  logic [15:0]        alpha_in,
	input  logic [31:0]        packed_in,
	output logic               out_valid,
	input  logic               out_stall,
	output hcp_pkg::cell_data_t out_data
);

	localparam logic [39:0] HDR_M = 40'd100 << (2 * FRACTION_BITS);

	logic [2:0][15:0] chan_c;
	logic [2:0][7:0]  byte_c;
	logic [2:0][31:0] sq_c;
	logic [2:0][47:0] t_c;
	logic [2:0][18:0] num_c;
	logic [2:0][23:0] w_c;
	logic [2:0][14:0] p_c;

	logic             v_s1, v_s2, v_s3;
	logic             st1, st2, st3;
	logic             func_s1, alpha_s1, func_s2, alpha_s2;
	logic [2:0][31:0] sq_s1;
	logic [2:0][47:0] t_s1, t_s2;
	logic [2:0][18:0] num_s1, num_s2;
	logic [2:0][3:0]  q1_c, q1_s2;
	logic [33:0]      s_s2;
	hcp_pkg::cell_data_t d_s3, d_c;

	assign st3      = v_s3 && out_stall;
	assign st2      = v_s2 && st3;
	assign st1      = v_s1 && st2;
	assign in_stall = st1;

	always_comb begin
		chan_c = {red_in, green_in, blue_in};
		byte_c = packed_in[23:0];
		for (int i = 0; i < 3; i++) begin
			sq_c[i]  = 32'(chan_c[i]) * 32'(chan_c[i]);
			w_c[i]   = {chan_c[i], 8'h00} - 24'(chan_c[i]);
			t_c[i]   = 48'(w_c[i]) * 48'(w_c[i]);
			p_c[i]   = 15'(byte_c[i]) * 15'(packed_in[30:24]);
			num_c[i] = (19'(p_c[i]) << 3) + (19'(p_c[i]) << 1);
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			q1_c[i] = 4'd0;
			for (int k = 1; k <= 10; k++) begin
				if (num_s1[i] >= 19'(k) * 19'(hcp_pkg::DIV_D)) begin
					q1_c[i] = 4'(k);
				end
			end
		end
	end

	always_comb begin
		d_c       = '0;
		d_c.func  = func_s2;
		d_c.alpha = alpha_s2;
		d_c.zero  = (s_s2 == '0);
		for (int i = 0; i < 3; i++) begin
			d_c.sq[i].m   = 40'(s_s2);
			d_c.sq[i].t   = t_s2[i];
			d_c.dv[i].q1  = q1_s2[i];
			d_c.dv[i].rem = 15'(num_s2[i] - 19'(q1_s2[i]) * 19'(hcp_pkg::DIV_D));
		end
		d_c.sq[hcp_pkg::HDR_LANE].m = HDR_M;
		d_c.sq[hcp_pkg::HDR_LANE].t = 48'(s_s2) * 48'(hcp_pkg::HDR_SQ);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (!st1) v_s1 <= in_valid;
			if (!st2) v_s2 <= v_s1;
			if (!st3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (!st1) begin
			func_s1  <= func;
			alpha_s1 <= func ? packed_in[31] : (alpha_in != 16'd0);
			sq_s1    <= sq_c;
			t_s1     <= t_c;
			num_s1   <= num_c;
		end
		if (!st2) begin
			func_s2  <= func_s1;
			alpha_s2 <= alpha_s1;
			s_s2     <= 34'(sq_s1[0]) + 34'(sq_s1[1]) + 34'(sq_s1[2]);
			t_s2     <= t_s1;
			num_s2   <= num_s1;
			q1_s2    <= q1_c;
		end
		if (!st3) begin
			d_s3 <= d_c;
		end
	end

	assign out_valid = v_s3;
	assign out_data  = d_s3;

endmodule

// ===== rtl/hcp_cell.sv =====
// One cell of the chain: one root bit on four lanes, two quotient bits on three.
// Depends on hcp_pkg.
module hcp_cell #(
	parameter int BIT = 7
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  hcp_pkg::cell_data_t in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output hcp_pkg::cell_data_t out_data
);

	logic                valid_q;
	hcp_pkg::cell_data_t data_q, next_c;

	assign in_stall = valid_q && out_stall;

	always_comb begin
		next_c = in_data;
		for (int l = 0; l < 4; l++) begin
			next_c.sq[l] = hcp_pkg::sq_step(in_data.sq[l], 3'(BIT));
		end
		for (int d = 0; d < 3; d++) begin
			next_c.dv[d] = hcp_pkg::div_step(hcp_pkg::div_step(in_data.dv[d]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!in_stall) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall) begin
			data_q <= next_c;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

// ===== test/tb_hdr_color_pack_unpack_unit.sv =====
// Testbench for the HDR color pack/unpack unit: directed and random encode/decode
// transactions, checked against a bit-exact integer predictor. Depends on the RTL only.
module tb_hdr_color_pack_unpack_unit;

	localparam int FRAC = 12;
	localparam logic OP_ENCODE = 1'b0;
	localparam logic OP_DECODE = 1'b1;
	localparam int STALL_LIMIT = 2000;

	typedef struct {
		logic [31:0] packed_w;
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
		logic        alpha;
	} color_result_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        func;
	logic [15:0] red_in;
	logic [15:0] green_in;
	logic [15:0] blue_in;
	logic [15:0] alpha_in;
	logic [31:0] packed_in;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] packed_out;
	logic [15:0] red_out;
	logic [15:0] green_out;
	logic [15:0] blue_out;
	logic        alpha_out;

	color_result_t pending_colors[$];
	int  error_count = 0;
	int  idle_cycles = 0;
	bit  calm_mode;

	hdr_color_pack_unpack_unit #(.FRACTION_BITS(FRAC)) uut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.func(func), .red_in(red_in), .green_in(green_in), .blue_in(blue_in),
		.alpha_in(alpha_in), .packed_in(packed_in), .out_valid(out_valid),
		.out_stall(out_stall), .packed_out(packed_out), .red_out(red_out),
		.green_out(green_out), .blue_out(blue_out), .alpha_out(alpha_out)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic longint unsigned root_byte(longint unsigned c, longint unsigned s);
		longint unsigned acc;
		longint unsigned k;
		longint unsigned num;
		acc = 0;
		num = 255 * c;
		for (int i = 7; i >= 0; i--) begin
			k = acc | (64'd1 << i);
			if (k * k * s <= num * num)
				acc = k;
		end
		return acc;
	endfunction

	function automatic longint unsigned hdr_scale(longint unsigned s);
		longint unsigned acc;
		longint unsigned h;
		longint unsigned lhs;
		acc = 0;
		for (int i = 6; i >= 0; i--) begin
			h = acc | (64'd1 << i);
			lhs = h * (64'd10 << FRAC);
			if (lhs * lhs <= 127 * 127 * s)
				acc = h;
		end
		return acc;
	endfunction

	function automatic logic [15:0] expand_channel(longint unsigned c, longint unsigned h);
		longint unsigned v;
		v = ((c * h * 10) << FRAC) / (255 * 127);
		return v > 64'hFFFF ? 16'hFFFF : v[15:0];
	endfunction

	function automatic color_result_t predict_color(logic op, logic [15:0] r, logic [15:0] g,
			logic [15:0] b, logic [15:0] a, logic [31:0] w);
		color_result_t res;
		longint unsigned s;
		res = '{default: '0};
		if (op == OP_ENCODE) begin
			s = longint'(r) * r + longint'(g) * g + longint'(b) * b;
			if (s != 0) begin
				res.packed_w[30:24] = hdr_scale(s);
				res.packed_w[23:16] = root_byte(r, s);
				res.packed_w[15:8]  = root_byte(g, s);
				res.packed_w[7:0]   = root_byte(b, s);
			end
			res.packed_w[31] = (a != 0);
		end else begin
			res.red   = expand_channel(w[23:16], w[30:24]);
			res.green = expand_channel(w[15:8], w[30:24]);
			res.blue  = expand_channel(w[7:0], w[30:24]);
			res.alpha = w[31];
		end
		return res;
	endfunction

	function automatic bit take_gap();
		return !calm_mode && ($urandom_range(99) < 32);
	endfunction

	task automatic send_color(logic op, logic [15:0] r, logic [15:0] g, logic [15:0] b,
			logic [15:0] a, logic [31:0] w);
		while (take_gap()) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		func      <= op;
		red_in    <= r;
		green_in  <= g;
		blue_in   <= b;
		alpha_in  <= a;
		packed_in <= w;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_colors.push_back(predict_color(op, r, g, b, a, w));
	endtask

	task automatic test_encode_directed();
		send_color(OP_ENCODE, 0, 0, 0, 0, 32'hFFFFFFFF);
		send_color(OP_ENCODE, 0, 0, 0, 16'h8000, 0);
		send_color(OP_ENCODE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0);
		send_color(OP_ENCODE, 16'hFFFF, 0, 0, 1, 0);
		send_color(OP_ENCODE, 0, 16'hFFFF, 0, 0, 0);
		send_color(OP_ENCODE, 0, 0, 16'hFFFF, 16'h8000, 0);
		send_color(OP_ENCODE, 1, 1, 1, 0, 0);
		send_color(OP_ENCODE, 16'd40960, 0, 0, 16'h0001, 0);
		send_color(OP_ENCODE, 16'd4096, 16'd4096, 16'd4096, 16'h7FFF, 0);
		send_color(OP_ENCODE, 16'h5555, 16'hAAAA, 16'h0001, 16'hAAAA, 0);
	endtask

	task automatic test_decode_directed();
		send_color(OP_DECODE, 0, 0, 0, 0, 32'h00000000);
		send_color(OP_DECODE, 0, 0, 0, 0, 32'hFFFFFFFF);
		send_color(OP_DECODE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h7FFFFFFF);
		send_color(OP_DECODE, 0, 0, 0, 0, 32'h80000000);
		send_color(OP_DECODE, 0, 0, 0, 0, 32'h7F000000);
		send_color(OP_DECODE, 0, 0, 0, 0, 32'h01FF00FF);
		send_color(OP_DECODE, 0, 0, 0, 0, 32'hA5A5A5A5);
		send_color(OP_DECODE, 0, 0, 0, 0, 32'h5A5A5A5A);
	endtask

	task automatic test_random_mix(int count);
		logic [15:0] r;
		logic [15:0] g;
		logic [15:0] b;
		int mode;
		for (int i = 0; i < count; i++) begin
			calm_mode = (i >= count / 2) && (i < count / 2 + 150);
			mode = $urandom_range(3);
			r = 16'($urandom);
			g = 16'($urandom);
			b = 16'($urandom);
			if (mode == 0) begin
				r = r >> $urandom_range(15);
				g = g >> $urandom_range(15);
				b = b >> $urandom_range(15);
			end
			if ($urandom_range(1))
				send_color(OP_ENCODE, r, g, b, $urandom_range(3) == 0 ? 16'd0 : 16'($urandom),
					$urandom);
			else
				send_color(OP_DECODE, 16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom), $urandom);
		end
		calm_mode = 1'b0;
	endtask

	always @(posedge clk) begin
		color_result_t exp_c;
		if (out_valid && !out_stall) begin
			if (pending_colors.size() == 0) begin
				$display("%0t unexpected result packed=%h", $time, packed_out);
				error_count++;
			end else begin
				exp_c = pending_colors.pop_front();
				if (packed_out !== exp_c.packed_w) begin
					$display("%0t packed_out exp %h got %h", $time, exp_c.packed_w, packed_out);
					error_count++;
				end
				if (red_out !== exp_c.red) begin
					$display("%0t red_out exp %h got %h", $time, exp_c.red, red_out);
					error_count++;
				end
				if (green_out !== exp_c.green) begin
					$display("%0t green_out exp %h got %h", $time, exp_c.green, green_out);
					error_count++;
				end
				if (blue_out !== exp_c.blue) begin
					$display("%0t blue_out exp %h got %h", $time, exp_c.blue, blue_out);
					error_count++;
				end
				if (alpha_out !== exp_c.alpha) begin
					$display("%0t alpha_out exp %b got %b", $time, exp_c.alpha, alpha_out);
					error_count++;
				end
			end
		end
		out_stall <= arst_n && take_gap();
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		func        = OP_ENCODE;
		red_in      = '0;
		green_in    = '0;
		blue_in     = '0;
		alpha_in    = '0;
		packed_in   = '0;
		calm_mode   = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_encode_directed();
		test_decode_directed();
		test_random_mix(1030);
		in_valid <= 1'b0;
		while (pending_colors.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
		if (error_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/hcp_pkg.sv
rtl/hcp_front.sv
rtl/hcp_cell.sv
rtl/hdr_color_pack_unpack_unit.sv
test/tb_hdr_color_pack_unpack_unit.sv
